@@ rtl/bdpc_pkg.sv @@
// Shared types and constants for the button debounce and press counter.
// Used by bdpc_core and button_debounce_press_counter; depends on nothing.
package bdpc_pkg;

  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTION_DELAY = 8'd1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] ACTION_DELAY_RESET = 16'd100;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] action_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic        level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [31:0] last_duration;
    logic [7:0]  press_count;
    logic        action_ready;
    logic        stable_level;
  } result_t;

endpackage

@@ rtl/bdpc_core.sv @@
// Debounce and press-session state with the per-item update logic.
// Depends on bdpc_pkg; instantiated by button_debounce_press_counter.
module bdpc_core #(
  parameter int unsigned TIME_BITS  = bdpc_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = bdpc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bdpc_pkg::item_t   item_i,
  input  bdpc_pkg::cfg_t    cfg_i,
  output bdpc_pkg::result_t result_o
);

  logic                  prev_raw_q, prev_raw_d;
  logic                  stable_q, stable_d;
  logic [TIME_BITS-1:0]  change_time_q, change_time_d;
  logic [TIME_BITS-1:0]  press_start_q, press_start_d;
  logic                  press_seen_q, press_seen_d;
  logic [TIME_BITS-1:0]  duration_q, duration_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  flag_q, flag_d;

  logic [63:0]           now_ext;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  since_change;
  logic [TIME_BITS-1:0]  since_press;
  logic [TIME_BITS-1:0]  since_press_d;
  logic [63:0]           dur_ext;
  logic [15:0]           count_ext;

  assign now_ext      = 64'(item_i.now_ms);
  assign now_t        = now_ext[TIME_BITS-1:0];
  assign since_change = now_t - change_time_d;
  assign since_press  = now_t - press_start_q;

  always_comb begin
    prev_raw_d    = prev_raw_q;
    stable_d      = stable_q;
    change_time_d = change_time_q;
    press_start_d = press_start_q;
    press_seen_d  = press_seen_q;
    duration_d    = duration_q;
    count_d       = count_q;
    flag_d        = flag_q;
    since_press_d = since_press;
    if (item_i.cmd == bdpc_pkg::CMD_CLEAR) begin
      flag_d     = 1'b0;
      duration_d = '0;
      count_d    = '0;
    end else begin
      if (item_i.level != prev_raw_q) begin
        change_time_d = now_t;
      end
      if ((since_change > TIME_BITS'(cfg_i.debounce_ms)) && (item_i.level != stable_q)) begin
        stable_d = item_i.level;
        if (item_i.level) begin
          press_start_d = now_t;
          press_seen_d  = 1'b1;
          since_press_d = '0;
        end else begin
          duration_d = since_press;
          count_d    = count_q + COUNT_BITS'(1);
        end
      end
      if (!flag_q && press_seen_d && (duration_d != '0) &&
          (since_press_d > TIME_BITS'(cfg_i.action_delay_ms))) begin
        flag_d = 1'b1;
      end
      prev_raw_d = item_i.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      change_time_q <= '0;
      press_start_q <= '0;
      press_seen_q  <= 1'b0;
      duration_q    <= '0;
      count_q       <= '0;
      flag_q        <= 1'b0;
    end else if (step_i) begin
      prev_raw_q    <= prev_raw_d;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
      press_start_q <= press_start_d;
      press_seen_q  <= press_seen_d;
      duration_q    <= duration_d;
      count_q       <= count_d;
      flag_q        <= flag_d;
    end
  end

  assign dur_ext   = 64'(duration_d);
  assign count_ext = 16'(count_d);

  assign result_o.stable_level  = stable_d;
  assign result_o.action_ready  = flag_d;
  assign result_o.press_count   = count_ext[7:0];
  assign result_o.last_duration = dur_ext[31:0];

endmodule

@@ rtl/button_debounce_press_counter.sv @@
// Top level of the button debounce and press counter: handshakes, registers, checks.
// Depends on bdpc_pkg and bdpc_core.
//
// Channel   Direction  Handshake             Contents
// s_axis    in         tvalid/tready         one switch sample or clear item
// m_axis    out        tvalid/tready         one result item per input item
// cfg       in         cfg_valid/cfg_ready   register index and 16-bit value
//
// An item passes from acceptance to result through an input register, then
// the state update and the result register. One item is accepted every cycle
// while the output is taken; a stalled output holds one result and one item in
// the input register before s_axis_tready falls. Asynchronous reset clears the
// valid flags and core state, not in_q or out_q; config returns to 50 and 100 ms.
module button_debounce_press_counter #(
  parameter int unsigned TIME_BITS  = bdpc_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = bdpc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // level [0], now_ms [32:1], zero [39:33]
  input  logic [39:0]                      s_axis_tdata,
  // cmd [0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // stable_level [0], action_ready [1], press_count [9:2],
  // last_duration [41:10], zero [47:42]
  output logic [47:0]                      m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic              in_valid_q;
  bdpc_pkg::item_t   in_q;
  logic              out_valid_q;
  bdpc_pkg::result_t out_q;
  bdpc_pkg::result_t core_result;
  bdpc_pkg::cfg_t    cfg_q;
  logic              out_adv;
  logic              core_step;
  logic              in_fire;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign core_step     = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= bdpc_pkg::DEBOUNCE_RESET;
      cfg_q.action_delay_ms <= bdpc_pkg::ACTION_DELAY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdpc_pkg::REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data_i;
        bdpc_pkg::REG_ACTION_DELAY: cfg_q.action_delay_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.cmd    <= s_axis_tuser[0];
      in_q.level  <= s_axis_tdata[0];
      in_q.now_ms <= s_axis_tdata[32:1];
    end
    if (core_step) begin
      out_q <= core_result;
    end
  end

  bdpc_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (core_step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (core_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.last_duration, out_q.press_count,
                          out_q.action_ready, out_q.stable_level};

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_step && in_q.cmd == bdpc_pkg::CMD_CLEAR) |=>
      (!out_q.action_ready && out_q.press_count == 8'd0 && out_q.last_duration == 32'd0))
    else $error("clear item did not zero the result");

  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_adv) |=> (in_valid_q && $stable(in_q)))
    else $error("input register changed while the output was stalled");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

endmodule
